/* rtl/icdf_pkg.sv */
package icdf_pkg;

	// Table geometry
	localparam int unsigned MAX_BINS = 1024;
	localparam int unsigned IDX_W    = $clog2(MAX_BINS);
	localparam int unsigned CNT_W    = IDX_W + 1;

	// Field widths
	localparam int unsigned WEIGHT_W = 16;
	localparam int unsigned POS_W    = 16;
	localparam int unsigned SUM_W    = 32;
	localparam int unsigned BIN_W    = 10;

	// Operation codes
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// Input word
	typedef struct packed {
		logic                operation;
		logic [WEIGHT_W-1:0] weight;
		logic                restart;
		logic [POS_W-1:0]    position;
	} icdf_in_t;

	// Output word
	typedef struct packed {
		logic [BIN_W-1:0] bin_index;
		logic             degenerate;
	} icdf_out_t;

	// Controller to datapath
	typedef struct packed {
		logic append;
		logic query;
		logic start;
		logic step;
		logic load_out;
	} icdf_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic count_lt2;
		logic search_done;
	} icdf_status_t;

endpackage

/* rtl/icdf_ram.sv */
module icdf_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/icdf_dp.sv */
module icdf_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  icdf_pkg::icdf_in_t   in_data,
	input  icdf_pkg::icdf_cmd_t  cmd,
	output icdf_pkg::icdf_status_t status,
	output icdf_pkg::icdf_out_t  out_data
);

	localparam int unsigned CNT_W  = icdf_pkg::CNT_W;
	localparam int unsigned IDX_W  = icdf_pkg::IDX_W;
	localparam int unsigned SUM_W  = icdf_pkg::SUM_W;
	localparam int unsigned POS_W  = icdf_pkg::POS_W;
	localparam int unsigned WGT_W  = icdf_pkg::WEIGHT_W;
	localparam int unsigned BIN_W  = icdf_pkg::BIN_W;

	logic [CNT_W-1:0]       count_q;
	logic [SUM_W-1:0]       total_q;
	logic [POS_W-1:0]       pos_q;
	logic [SUM_W-1:0]       target_q;
	logic [CNT_W-1:0]       lo_q;
	logic [CNT_W-1:0]       hi_q;
	logic [CNT_W-1:0]       mid_q;
	icdf_pkg::icdf_out_t    out_q;

	logic [CNT_W-1:0]       eff_count;
	logic [SUM_W-1:0]       eff_total;
	logic [SUM_W:0]         sum_ext;
	logic [SUM_W-1:0]       new_total;
	logic                   has_room;
	logic                   ram_we;
	logic [POS_W+SUM_W-1:0] product;
	logic [SUM_W-1:0]       rdata;
	logic                   not_above;
	logic [CNT_W-1:0]       lo_n;
	logic [CNT_W-1:0]       hi_n;
	logic [CNT_W:0]         mid_sum;
	logic [CNT_W-1:0]       mid_n;
	logic [CNT_W-1:0]       start_mid;
	logic [IDX_W-1:0]       raddr;
	logic [CNT_W-1:0]       last_idx;
	logic [CNT_W-1:0]       capped;

	// Append: restart clears the table, then the new prefix sum is written at count
	assign eff_count = in_data.restart ? '0 : count_q;
	assign eff_total = in_data.restart ? '0 : total_q;
	assign sum_ext   = {1'b0, eff_total} + {{(SUM_W + 1 - WGT_W){1'b0}}, in_data.weight};
	assign new_total = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
	assign has_room  = eff_count < CNT_W'(icdf_pkg::MAX_BINS);
	assign ram_we    = cmd.append && has_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else if (cmd.append) begin
			if (has_room) begin
				count_q <= eff_count + CNT_W'(1);
				total_q <= new_total;
			end else begin
				count_q <= eff_count;
				total_q <= eff_total;
			end
		end
	end

	// Scaled target: floor(position * total / 2^POS_W)
	assign product = {{SUM_W{1'b0}}, pos_q} * {{POS_W{1'b0}}, total_q};

	// Search step: compare the entry at mid with the target, narrow [lo, hi]
	assign not_above = rdata <= target_q;
	assign lo_n      = not_above ? mid_q + CNT_W'(1) : lo_q;
	assign hi_n      = not_above ? hi_q : mid_q;
	assign mid_sum   = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n     = mid_sum[CNT_W:1];
	assign start_mid = count_q >> 1;
	assign raddr     = cmd.start ? start_mid[IDX_W-1:0] : mid_n[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.query) begin
			pos_q <= in_data.position;
		end
		if (cmd.start) begin
			target_q <= product[POS_W+SUM_W-1:POS_W];
			lo_q     <= '0;
			hi_q     <= count_q;
			mid_q    <= start_mid;
		end else if (cmd.step) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
	end

	icdf_ram #(
		.WIDTH(SUM_W),
		.DEPTH(icdf_pkg::MAX_BINS)
	) u_sums (
		.clk  (clk),
		.we   (ram_we),
		.waddr(eff_count[IDX_W-1:0]),
		.wdata(new_total),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Result: capped at the last stored bin
	assign last_idx = count_q - CNT_W'(1);
	assign capped   = (lo_q > last_idx) ? last_idx : lo_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.bin_index  <= status.count_lt2 ? '0 : capped[BIN_W-1:0];
			out_q.degenerate <= status.count_lt2;
		end
	end

	assign status.count_lt2   = count_q < CNT_W'(2);
	assign status.search_done = !(lo_n < hi_n);
	assign out_data           = out_q;

endmodule

/* rtl/icdf_ctrl.sv */
module icdf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_operation,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  icdf_pkg::icdf_status_t status,
	output icdf_pkg::icdf_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_SRCH = 4'b0100,
		ST_WAIT = 4'b1000
	} icdf_state_t;

	icdf_state_t state_q;
	icdf_state_t state_n;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_operation == icdf_pkg::OP_QUERY) begin
						cmd.query = 1'b1;
						state_n   = ST_MUL;
					end else begin
						cmd.append = 1'b1;
					end
				end
			end
			ST_MUL: begin
				cmd.start = 1'b1;
				state_n   = status.count_lt2 ? ST_WAIT : ST_SRCH;
			end
			ST_SRCH: begin
				cmd.step = 1'b1;
				if (status.search_done) begin
					state_n = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/inverse_cdf_bin_sampler_top.sv */
// Inverse-CDF bin sampler. Append words (operation 0) add a 16-bit weight to a table of up
// to 1024 running prefix sums; restart starts a new table, and appends to a full table are
// dropped. A query word (operation 1) scales its Q0.16 position by the total weight and
// binary-searches the table, returning the number of prefix sums not above the scaled value,
// capped at the last bin; with fewer than two bins it returns bin 0 with degenerate set. A
// query passes through acceptance, a multiply state, the search steps (ceil(log2(bins + 1)),
// at most 11, each a read from the single read port of the sum memory) and a load of the
// output register, which waits for a free output slot. Words are taken one at a time; a
// new word is accepted while the previous result still waits in the output register.
module inverse_cdf_bin_sampler_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  icdf_pkg::icdf_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output icdf_pkg::icdf_out_t out_data
);

	icdf_pkg::icdf_cmd_t    cmd;
	icdf_pkg::icdf_status_t status;

	icdf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_operation(in_data.operation),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.cmd         (cmd)
	);

	icdf_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (in_data),
		.cmd     (cmd),
		.status  (status),
		.out_data(out_data)
	);

endmodule

/* test/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RAND_WORDS = 500;
	localparam int unsigned QUIET_FROM = 440;
	localparam int unsigned DRAIN_CYCLES = 20;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	icdf_pkg::icdf_in_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	icdf_pkg::icdf_out_t out_data;

	// Directed row: the word, plus a hand-written answer where it is obvious
	typedef struct {
		icdf_pkg::icdf_in_t  word;
		bit                  typed;
		icdf_pkg::icdf_out_t answer;
	} dir_row_t;

	// Shadow copy of the table
	logic [icdf_pkg::SUM_W-1:0] sum_table [icdf_pkg::MAX_BINS];
	int unsigned                stored_bins = 0;

	icdf_pkg::icdf_out_t pending_bins [$];
	int                  errs = 0;
	bit                  quiet = 1'b0;
	int                  hold_cycles = 0;

	inverse_cdf_bin_sampler_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic icdf_pkg::icdf_in_t make_word(logic op,
			logic [icdf_pkg::WEIGHT_W-1:0] weight, logic restart,
			logic [icdf_pkg::POS_W-1:0] pos);
		icdf_pkg::icdf_in_t w;
		w.operation = op;
		w.weight    = weight;
		w.restart   = restart;
		w.position  = pos;
		return w;
	endfunction

	function automatic dir_row_t make_row(icdf_pkg::icdf_in_t w, bit typed,
			logic [icdf_pkg::BIN_W-1:0] bin, logic degen);
		dir_row_t r;
		r.word = w;
		r.typed = typed;
		r.answer.bin_index = bin;
		r.answer.degenerate = degen;
		return r;
	endfunction

	// Field values biased toward the edges
	function automatic logic [15:0] rand_field();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	// Update the shadow table and queue the answer a query should get
	task automatic predict_word(icdf_pkg::icdf_in_t w);
		logic [icdf_pkg::SUM_W:0] acc;
		logic [63:0]              scaled;
		int unsigned              lo;
		int unsigned              hi;
		int unsigned              mid;
		icdf_pkg::icdf_out_t      res;
		if (w.operation == icdf_pkg::OP_APPEND) begin
			if (w.restart)
				stored_bins = 0;
			if (stored_bins < icdf_pkg::MAX_BINS) begin
				acc = (icdf_pkg::SUM_W+1)'(w.weight);
				if (stored_bins > 0)
					acc = acc + sum_table[stored_bins-1];
				if (acc[icdf_pkg::SUM_W])
					acc = {1'b0, {icdf_pkg::SUM_W{1'b1}}};
				sum_table[stored_bins] = acc[icdf_pkg::SUM_W-1:0];
				stored_bins++;
			end
		end else begin
			if (stored_bins < 2) begin
				res.bin_index = '0;
				res.degenerate = 1'b1;
			end else begin
				scaled = (64'(w.position) * 64'(sum_table[stored_bins-1]))
					>> icdf_pkg::POS_W;
				lo = 0;
				hi = stored_bins;
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if (64'(sum_table[mid]) <= scaled)
						lo = mid + 1;
					else
						hi = mid;
				end
				if (lo > stored_bins - 1)
					lo = stored_bins - 1;
				res.bin_index = lo[icdf_pkg::BIN_W-1:0];
				res.degenerate = 1'b0;
			end
			pending_bins.push_back(res);
		end
	endtask

	// Offer one word, with an occasional idle burst in front of it
	task automatic send_word(icdf_pkg::icdf_in_t w, bit typed, icdf_pkg::icdf_out_t answer);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		if (typed && w.operation == icdf_pkg::OP_QUERY)
			pending_bins.push_back(answer);
		else
			predict_word(w);
	endtask

	// Result side stalls in random bursts
	always @(posedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			hold_cycles <= $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each result word against the oldest expectation
	always @(posedge clk) begin
		icdf_pkg::icdf_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bins.size() == 0) begin
				$display("%0t: unexpected result word bin_index %0d degenerate %0d",
					$time, out_data.bin_index, out_data.degenerate);
				errs++;
			end else begin
				want = pending_bins.pop_front();
				if (out_data.bin_index !== want.bin_index) begin
					$display("%0t: bin_index expected %0d actual %0d",
						$time, want.bin_index, out_data.bin_index);
					errs++;
				end
				if (out_data.degenerate !== want.degenerate) begin
					$display("%0t: degenerate expected %0d actual %0d",
						$time, want.degenerate, out_data.degenerate);
					errs++;
				end
			end
		end
	end

	// Hard stop if the run hangs
	initial begin
		#(12 * 400_000);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		dir_row_t    dir_plan [$];
		int unsigned rand_words;
		int unsigned nb;
		int unsigned nq;
		logic        rs;

		// Empty table, one bin, zero total, then edge weights and positions
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_QUERY, 16'h0000, 1'b0, 16'h0000),
			1, 0, 1));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_QUERY, 16'hFFFF, 1'b1, 16'hFFFF),
			1, 0, 1));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_APPEND, 16'h0000, 1'b1, 16'hFFFF),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_QUERY, 16'h1234, 1'b0, 16'hFFFF),
			1, 0, 1));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_APPEND, 16'h0000, 1'b0, 16'h0000),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_QUERY, 16'h0000, 1'b0, 16'h8000),
			1, 1, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_QUERY, 16'hFFFF, 1'b1, 16'hFFFF),
			1, 1, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_APPEND, 16'hFFFF, 1'b1, 16'h0000),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_APPEND, 16'hFFFF, 1'b0, 16'hFFFF),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_QUERY, 16'h0000, 1'b0, 16'h0000),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_QUERY, 16'h0000, 1'b0, 16'hFFFF),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_QUERY, 16'hFFFF, 1'b0, 16'h8000),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_APPEND, 16'h0001, 1'b1, 16'h5555),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_APPEND, 16'h0000, 1'b0, 16'hAAAA),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_APPEND, 16'h0002, 1'b0, 16'h0000),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_APPEND, 16'h0000, 1'b0, 16'hFFFF),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_QUERY, 16'h5555, 1'b0, 16'h0000),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_QUERY, 16'hAAAA, 1'b0, 16'h4000),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_QUERY, 16'h0000, 1'b1, 16'hC000),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_QUERY, 16'hFFFF, 1'b0, 16'hFFFF),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_APPEND, 16'hAAAA, 1'b0, 16'h1234),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_APPEND, 16'h5555, 1'b0, 16'hEDCB),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_QUERY, 16'h0F0F, 1'b0, 16'h5555),
			0, 0, 0));
		dir_plan.push_back(make_row(make_word(icdf_pkg::OP_QUERY, 16'hF0F0, 1'b0, 16'hAAAA),
			0, 0, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_plan[i])
			send_word(dir_plan[i].word, dir_plan[i].typed, dir_plan[i].answer);

		// Fill the table to the top, push past it, then search the full table
		send_word(make_word(icdf_pkg::OP_APPEND, rand_field(), 1'b1, rand_field()), 0, '0);
		repeat (icdf_pkg::MAX_BINS - 1 + 4)
			send_word(make_word(icdf_pkg::OP_APPEND, 16'($urandom), 1'b0, 16'($urandom)),
				0, '0);
		send_word(make_word(icdf_pkg::OP_QUERY, rand_field(), 1'b0, 16'h0000), 0, '0);
		send_word(make_word(icdf_pkg::OP_QUERY, rand_field(), 1'b0, 16'hFFFF), 0, '0);
		repeat (6)
			send_word(make_word(icdf_pkg::OP_QUERY, 16'($urandom), 1'($urandom),
				16'($urandom)), 0, '0);
		send_word(make_word(icdf_pkg::OP_APPEND, rand_field(), 1'b1, rand_field()), 0, '0);
		send_word(make_word(icdf_pkg::OP_QUERY, rand_field(), 1'b0, rand_field()), 0, '0);

		// Random tables: a restart, some appends with queries mixed in, then a run of queries
		rand_words = 0;
		while (rand_words < RAND_WORDS) begin
			case ($urandom_range(0, 19))
				0: nb = $urandom_range(65, 300);
				1, 2, 3, 4, 5: nb = $urandom_range(9, 64);
				default: nb = $urandom_range(1, 8);
			endcase
			for (int unsigned i = 0; i < nb; i++) begin
				rs = (i == 0) || ($urandom_range(0, 49) == 0);
				send_word(make_word(icdf_pkg::OP_APPEND, rand_field(), rs,
					16'($urandom)), 0, '0);
				rand_words++;
				if ($urandom_range(0, 9) == 0) begin
					send_word(make_word(icdf_pkg::OP_QUERY, 16'($urandom), 1'($urandom),
						rand_field()), 0, '0);
					rand_words++;
				end
				if (rand_words >= QUIET_FROM)
					quiet = 1'b1;
			end
			nq = $urandom_range(1, 8);
			repeat (nq) begin
				send_word(make_word(icdf_pkg::OP_QUERY, 16'($urandom), 1'($urandom),
					rand_field()), 0, '0);
				rand_words++;
			end
			if (rand_words >= QUIET_FROM)
				quiet = 1'b1;
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then watch for stray words
		while (pending_bins.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_bins.size() != 0)
			$display("%0t: %0d expected result words never arrived", $time, pending_bins.size());
		if (errs == 0 && pending_bins.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* inverse_cdf_bin_sampler_top.f */
rtl/icdf_pkg.sv
rtl/icdf_ram.sv
rtl/icdf_dp.sv
rtl/icdf_ctrl.sv
rtl/inverse_cdf_bin_sampler_top.sv
test/tb_top.sv
